>>> sv/pct_pkg.sv
`timescale 1ns / 1ps

package pct_pkg;

    localparam int COORD_W   = 16;
    localparam int ID_W      = 8;
    localparam int GAIN_W    = 20;
    localparam int BTN_W     = 8;
    localparam int Q16_SHIFT = 16;

    // Unity gain in unsigned Q16.
    localparam logic [GAIN_W-1:0] Q16_ONE = 20'h10000;

    localparam logic OP_ABS    = 1'b0;
    localparam logic OP_REL    = 1'b1;
    localparam logic EV_MOTION = 1'b0;
    localparam logic EV_SCROLL = 1'b1;

    typedef struct packed {
        logic                      opcode;
        logic [ID_W-1:0]           origin_id;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0]        range_x;
        logic [COORD_W-1:0]        range_y;
        logic [GAIN_W-1:0]         accel_gain;
        logic [BTN_W-1:0]          button_mask;
        logic signed [COORD_W-1:0] scroll_amount;
    } t_req_item;

    typedef struct packed {
        logic                      event_kind;
        logic [ID_W-1:0]           source_id;
        logic [COORD_W-1:0]        pos_x;
        logic [COORD_W-1:0]        pos_y;
        logic [BTN_W-1:0]          buttons_out;
        logic signed [COORD_W-1:0] scroll_delta;
        logic                      last;
    } t_rsp_item;

    typedef struct packed {
        logic              start;
        logic              opcode;
        logic [GAIN_W-1:0] gain;
    } t_lane_req;

    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] pos;
    } t_lane_rsp;

endpackage

>>> sv/pct_ifs.sv
`timescale 1ns / 1ps

interface pct_req_if;
    import pct_pkg::*;

    logic      valid;
    logic      ready;
    t_req_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pct_rsp_if;
    import pct_pkg::*;

    logic      valid;
    logic      ready;
    t_rsp_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/pct_lane.sv
`timescale 1ns / 1ps

module pct_lane #(
    parameter int VIRTUAL_MAX = 65535,
    parameter int REL_SCALE   = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  pct_pkg::t_lane_req                       i_req,
    input  logic signed [pct_pkg::COORD_W-1:0]       i_coord,
    input  logic [pct_pkg::COORD_W-1:0]              i_range,
    output pct_pkg::t_lane_rsp                       o_rsp
);
    import pct_pkg::*;

    localparam int VM_W    = $clog2(VIRTUAL_MAX + 1);
    localparam int RS_W    = $clog2(REL_SCALE + 1);
    localparam int ABS_W   = COORD_W + VM_W;
    localparam int MAG_W   = ABS_W - 1;
    localparam int DIV_W   = MAG_W + (MAG_W % 2);
    localparam int STEPS   = DIV_W / 2;
    localparam int CNT_W   = $clog2(STEPS + 1);
    localparam int REL_W   = COORD_W + RS_W;
    localparam int GP_W    = REL_W + GAIN_W + 1;
    localparam int ACC_W   = (ABS_W > GP_W) ? ABS_W : GP_W;
    localparam int SUM_W   = ACC_W + 1;
    localparam int CUR_RST = VIRTUAL_MAX / 2;

    localparam logic [VM_W-1:0]    VM_L  = VM_W'(VIRTUAL_MAX);
    localparam logic [RS_W-1:0]    RS_L  = RS_W'(REL_SCALE);
    localparam logic [COORD_W-1:0] VM_16 = COORD_W'(VIRTUAL_MAX);

    typedef enum logic [4:0] {
        L_IDLE  = 5'b00001,
        L_SCALE = 5'b00010,
        L_DIV   = 5'b00100,
        L_GAIN  = 5'b01000,
        L_SUM   = 5'b10000
    } t_lane_state;

    t_lane_state                r_state, n_state;
    logic                       r_done, n_done;
    logic [COORD_W-1:0]         r_cur, n_cur;
    logic                       r_op, n_op;
    logic [GAIN_W-1:0]          r_gain, n_gain;
    logic signed [COORD_W-1:0]  r_coord, n_coord;
    logic [COORD_W-1:0]         r_den, n_den;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic                       r_neg, n_neg;
    logic [COORD_W-1:0]         r_rem, n_rem;
    logic [DIV_W-1:0]           r_quo, n_quo;
    logic [CNT_W-1:0]           r_cnt, n_cnt;

    logic signed [ABS_W-1:0]    w_abs_prod;
    logic [ABS_W-1:0]           w_abs_mag;
    logic signed [REL_W-1:0]    w_rel_prod;
    logic signed [GP_W-1:0]     w_gain_prod;
    logic signed [SUM_W-1:0]    w_sum;
    logic [COORD_W:0]           w_rem_a, w_rem_a2, w_rem_b, w_rem_b2;
    logic                       w_ge_a, w_ge_b;
    logic [COORD_W-1:0]         w_abs_pos, w_rel_pos;

    // Raw value times the virtual maximum; the divider works on its magnitude.
    assign w_abs_prod = ABS_W'(r_coord) * ABS_W'($signed({1'b0, VM_L}));
    assign w_abs_mag  = w_abs_prod[ABS_W-1] ? ABS_W'(-w_abs_prod) : ABS_W'(w_abs_prod);

    assign w_rel_prod  = REL_W'(r_coord) * REL_W'($signed({1'b0, RS_L}));
    assign w_gain_prod = GP_W'($signed(r_acc[REL_W-1:0])) * GP_W'($signed({1'b0, r_gain}));

    // Two restoring division steps per cycle.
    assign w_rem_a  = {r_rem, r_quo[DIV_W-1]};
    assign w_ge_a   = (w_rem_a >= {1'b0, r_den});
    assign w_rem_a2 = w_ge_a ? (w_rem_a - {1'b0, r_den}) : w_rem_a;
    assign w_rem_b  = {w_rem_a2[COORD_W-1:0], r_quo[DIV_W-2]};
    assign w_ge_b   = (w_rem_b >= {1'b0, r_den});
    assign w_rem_b2 = w_ge_b ? (w_rem_b - {1'b0, r_den}) : w_rem_b;

    // A negative quotient always clamps to zero, so only its sign matters.
    assign w_abs_pos = r_neg ? '0
                     : (r_quo > DIV_W'(VIRTUAL_MAX)) ? VM_16
                     : r_quo[COORD_W-1:0];

    assign w_sum     = SUM_W'(r_acc) + SUM_W'($signed({1'b0, r_cur}));
    assign w_rel_pos = w_sum[SUM_W-1] ? '0
                     : (w_sum > $signed(SUM_W'(VIRTUAL_MAX))) ? VM_16
                     : w_sum[COORD_W-1:0];

    always_comb begin
        n_state = r_state;
        n_done  = r_done;
        n_cur   = r_cur;
        n_op    = r_op;
        n_gain  = r_gain;
        n_coord = r_coord;
        n_den   = r_den;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        case (r_state)
            L_IDLE: begin
                if (i_req.start) begin
                    n_op    = i_req.opcode;
                    n_gain  = i_req.gain;
                    n_coord = i_coord;
                    n_den   = (i_range == '0) ? COORD_W'(1) : i_range;
                    n_done  = 1'b0;
                    n_state = L_SCALE;
                end
            end
            L_SCALE: begin
                if (r_op == OP_ABS) begin
                    n_neg   = w_abs_prod[ABS_W-1];
                    n_quo   = DIV_W'(w_abs_mag[MAG_W-1:0]);
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = L_DIV;
                end else begin
                    n_acc   = ACC_W'(w_rel_prod);
                    n_state = L_GAIN;
                end
            end
            L_DIV: begin
                n_rem = w_rem_b2[COORD_W-1:0];
                n_quo = {r_quo[DIV_W-3:0], w_ge_a, w_ge_b};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    n_state = L_SUM;
                end
            end
            L_GAIN: begin
                if (r_gain > Q16_ONE) begin
                    n_acc = ACC_W'(w_gain_prod >>> Q16_SHIFT);
                end
                n_state = L_SUM;
            end
            L_SUM: begin
                n_cur   = (r_op == OP_ABS) ? w_abs_pos : w_rel_pos;
                n_done  = 1'b1;
                n_state = L_IDLE;
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
            r_cur   <= COORD_W'(CUR_RST);
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cur   <= n_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_gain  <= n_gain;
        r_coord <= n_coord;
        r_den   <= n_den;
        r_acc   <= n_acc;
        r_neg   <= n_neg;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_cnt   <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.pos  = r_cur;

endmodule

>>> sv/pointer_coordinate_transform_core.sv
`timescale 1ns / 1ps
// An absolute report passes through each lane's scale, divide and sum states, with
// two quotient bits per cycle in the divider; a relative report through scale, gain
// and sum. One report is in flight at a time: a new one is accepted only after the
// motion result and any scroll result have been taken.
// Reset (synchronous, active low) puts both cursor coordinates at VIRTUAL_MAX / 2.

module pointer_coordinate_transform_core #(
    parameter int VIRTUAL_MAX = 65535,
    parameter int REL_SCALE   = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pct_req_if.sink   i_req,
    pct_rsp_if.source o_rsp
);
    import pct_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_BUSY   = 4'b0010,
        ST_MOTION = 4'b0100,
        ST_SCROLL = 4'b1000
    } t_state;

    t_state                    r_state, n_state;
    logic [ID_W-1:0]           r_dev;
    logic [BTN_W-1:0]          r_btn;
    logic signed [COORD_W-1:0] r_scroll;
    t_rsp_item                 r_out, n_out;

    logic      w_accept;
    t_lane_req w_lane_req;
    t_lane_rsp w_rsp_x, w_rsp_y;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_lane_req.start  = w_accept;
    assign w_lane_req.opcode = i_req.data.opcode;
    assign w_lane_req.gain   = i_req.data.accel_gain;

    pct_lane #(
        .VIRTUAL_MAX (VIRTUAL_MAX),
        .REL_SCALE   (REL_SCALE)
    ) u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_lane_req),
        .i_coord (i_req.data.coord_x),
        .i_range (i_req.data.range_x),
        .o_rsp   (w_rsp_x)
    );

    pct_lane #(
        .VIRTUAL_MAX (VIRTUAL_MAX),
        .REL_SCALE   (REL_SCALE)
    ) u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_lane_req),
        .i_coord (i_req.data.coord_y),
        .i_range (i_req.data.range_y),
        .o_rsp   (w_rsp_y)
    );

    // Merge the two lanes into the motion transaction, then the optional scroll one.
    always_comb begin
        n_state = r_state;
        n_out   = r_out;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (w_rsp_x.done && w_rsp_y.done) begin
                    n_out.event_kind   = EV_MOTION;
                    n_out.source_id    = r_dev;
                    n_out.pos_x        = w_rsp_x.pos;
                    n_out.pos_y        = w_rsp_y.pos;
                    n_out.buttons_out  = r_btn;
                    n_out.scroll_delta = '0;
                    n_out.last         = (r_scroll == '0);
                    n_state            = ST_MOTION;
                end
            end
            ST_MOTION: begin
                if (o_rsp.ready) begin
                    if (r_scroll != '0) begin
                        n_out.event_kind   = EV_SCROLL;
                        n_out.source_id    = r_dev;
                        n_out.pos_x        = '0;
                        n_out.pos_y        = '0;
                        n_out.buttons_out  = '0;
                        n_out.scroll_delta = r_scroll;
                        n_out.last         = 1'b1;
                        n_state            = ST_SCROLL;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SCROLL: begin
                if (o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_accept) begin
            r_dev    <= i_req.data.origin_id;
            r_btn    <= i_req.data.button_mask;
            r_scroll <= i_req.data.scroll_amount;
        end
    end

    assign o_rsp.valid = (r_state == ST_MOTION) || (r_state == ST_SCROLL);
    assign o_rsp.data  = r_out;

    // Both lanes run the same schedule, so they must finish together.
    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BUSY) |-> (w_rsp_x.done == w_rsp_y.done))
        else $error("lanes finished on different cycles");

    // A new report clears the lane results before the merge can look at them.
    a_done_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (!w_rsp_x.done && !w_rsp_y.done))
        else $error("stale lane result after a new report");

    a_scroll_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL) |-> (o_rsp.data.scroll_delta != '0))
        else $error("scroll transaction with zero delta");

    a_motion_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOTION) |-> (o_rsp.data.last == (r_scroll == '0)))
        else $error("motion transaction last flag disagrees with scroll");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.data.event_kind == EV_MOTION))
        |-> ((o_rsp.data.pos_x <= COORD_W'(VIRTUAL_MAX))
            && (o_rsp.data.pos_y <= COORD_W'(VIRTUAL_MAX))))
        else $error("cursor outside the virtual range");

endmodule

>>> tb/tb_pointer_coordinate_transform_core.sv
`timescale 1ns / 1ps

module tb_pointer_coordinate_transform_core;
    import pct_pkg::*;

    localparam int VMAX         = 65535;
    localparam int REL_MUL      = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int ITEMS_PER_PHASE = 135;

    typedef struct {
        t_req_item   req;
        bit          pinned;
        logic [15:0] px;
        logic [15:0] py;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    pct_req_if req_bus ();
    pct_rsp_if rsp_bus ();

    pointer_coordinate_transform_core #(
        .VIRTUAL_MAX (VMAX),
        .REL_SCALE   (REL_MUL)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    logic [15:0] track_x;
    logic [15:0] track_y;
    t_rsp_item   pending_events[$];
    t_dir_row    dir_rows[$];
    int          error_count;
    int          cycle_count;
    int          src_idle_pct;
    int          snk_idle_pct;
    bit          hold_request;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] clamp_canvas(longint v);
        if (v < 0) return 16'd0;
        if (v > VMAX) return 16'(VMAX);
        return 16'(v);
    endfunction

    // Truncating division, as the absolute mapping requires.
    function automatic longint scale_absolute(logic signed [15:0] raw, logic [15:0] span);
        longint den;
        longint num;
        den = (span == 16'd0) ? 64'sd1 : longint'({48'd0, span});
        num = longint'(raw) * VMAX;
        return num / den;
    endfunction

    // The gain only applies above unity; the shift floors toward minus infinity.
    function automatic longint scale_relative(logic signed [15:0] d, logic [19:0] gain);
        longint c;
        c = longint'(d) * REL_MUL;
        if (gain > Q16_ONE) c = (c * longint'({44'd0, gain})) >>> Q16_SHIFT;
        return c;
    endfunction

    function automatic void predict_report(t_req_item r, bit pinned,
                                           logic [15:0] px, logic [15:0] py);
        t_rsp_item ev;
        if (r.opcode == OP_ABS) begin
            track_x = clamp_canvas(scale_absolute(r.coord_x, r.range_x));
            track_y = clamp_canvas(scale_absolute(r.coord_y, r.range_y));
        end else begin
            track_x = clamp_canvas(longint'({48'd0, track_x})
                                   + scale_relative(r.coord_x, r.accel_gain));
            track_y = clamp_canvas(longint'({48'd0, track_y})
                                   + scale_relative(r.coord_y, r.accel_gain));
        end
        if (pinned) begin
            track_x = px;
            track_y = py;
        end
        ev = '0;
        ev.event_kind  = EV_MOTION;
        ev.source_id   = r.origin_id;
        ev.pos_x       = track_x;
        ev.pos_y       = track_y;
        ev.buttons_out = r.button_mask;
        ev.last        = (r.scroll_amount == 16'sd0);
        pending_events.push_back(ev);
        if (r.scroll_amount != 16'sd0) begin
            ev = '0;
            ev.event_kind   = EV_SCROLL;
            ev.source_id    = r.origin_id;
            ev.scroll_delta = r.scroll_amount;
            ev.last         = 1'b1;
            pending_events.push_back(ev);
        end
    endfunction

    function automatic t_req_item mk(logic op, int dev, int cx, int cy, int rx, int ry,
                                     int gain, int btn, int scr);
        t_req_item r;
        r.opcode        = op;
        r.origin_id     = 8'(dev);
        r.coord_x       = 16'(cx);
        r.coord_y       = 16'(cy);
        r.range_x       = 16'(rx);
        r.range_y       = 16'(ry);
        r.accel_gain    = 20'(gain);
        r.button_mask   = 8'(btn);
        r.scroll_amount = 16'(scr);
        return r;
    endfunction

    // Mostly plausible reports (in-range absolute coordinates, modest deltas and gains),
    // with some fully random transactions mixed in.
    function automatic t_req_item rand_report();
        t_req_item r;
        int        span_x;
        int        span_y;
        r = mk(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom);
        if ($urandom_range(99) >= 15) begin
            if (r.opcode == OP_ABS) begin
                span_x = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(65535);
                span_y = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(65535);
                r.range_x = 16'(span_x);
                r.range_y = 16'(span_y);
                r.coord_x = 16'($urandom_range((span_x > 32767) ? 32767 : span_x));
                r.coord_y = 16'($urandom_range((span_y > 32767) ? 32767 : span_y));
            end else begin
                r.coord_x    = 16'(int'($urandom_range(400)) - 200);
                r.coord_y    = 16'(int'($urandom_range(400)) - 200);
                r.accel_gain = 20'($urandom_range(4 * 65536));
            end
            if ($urandom_range(1) == 0) r.scroll_amount = 16'sd0;
        end
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_report(t_req_item r, bit pinned, logic [15:0] px, logic [15:0] py);
        while ($urandom_range(99) < src_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.data  <= r;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        predict_report(r, pinned, px, py);
    endtask

    // Result side: check each completed transaction, then pick the next ready value.
    initial begin
        t_rsp_item want;
        t_rsp_item got;
        int        hold_left;
        hold_left = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_bus.valid && rsp_bus.ready) begin
                got = rsp_bus.data;
                if (pending_events.size() == 0) begin
                    $error("unexpected result: source_id %0d, event_kind %0d",
                           got.source_id, got.event_kind);
                    error_count++;
                end else begin
                    want = pending_events.pop_front();
                    check_field("event_kind", int'(want.event_kind), int'(got.event_kind));
                    check_field("source_id", int'(want.source_id), int'(got.source_id));
                    check_field("pos_x", int'(want.pos_x), int'(got.pos_x));
                    check_field("pos_y", int'(want.pos_y), int'(got.pos_y));
                    check_field("buttons_out", int'(want.buttons_out),
                                int'(got.buttons_out));
                    check_field("scroll_delta", int'(want.scroll_delta),
                                int'(got.scroll_delta));
                    check_field("last", int'(want.last), int'(got.last));
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                rsp_bus.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_pointer_coordinate_transform_core: done, errors");
        $finish;
    end

    initial begin
        error_count   = 0;
        hold_request  = 1'b0;
        src_idle_pct  = 21;
        snk_idle_pct  = 50;
        i_rst_n       <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.data  <= '0;

        // Absolute rows use opcode OP_ABS, relative rows OP_REL; pinned rows carry
        // the cursor position that can be read straight off the mapping.
        dir_rows.push_back('{mk(OP_REL, 8'h00, 0, 0, 0, 0, 0, 8'hFF, 0),
                             1'b1, 16'd32767, 16'd32767});
        dir_rows.push_back('{mk(OP_ABS, 8'h01, 32767, 0, 32767, 100, 0, 8'h01, 0),
                             1'b1, 16'd65535, 16'd0});
        dir_rows.push_back('{mk(OP_ABS, 8'h02, 1, -1, 0, 0, 0, 8'h02, 0),
                             1'b1, 16'd65535, 16'd0});
        dir_rows.push_back('{mk(OP_ABS, 8'h03, -32768, 32767, 65535, 65535, 0, 8'h04, 0),
                             1'b1, 16'd0, 16'd32767});
        dir_rows.push_back('{mk(OP_ABS, 8'h04, 1000, 5, 10, 10, 0, 8'h08, 0),
                             1'b1, 16'd65535, 16'd32767});
        dir_rows.push_back('{mk(OP_ABS, 8'h05, -5, -32768, 10, 65535, 0, 8'h10, 0),
                             1'b1, 16'd0, 16'd0});
        dir_rows.push_back('{mk(OP_ABS, 8'h06, 1, 2, 3, 3, 0, 8'h20, 32767),
                             1'b1, 16'd21845, 16'd43690});
        dir_rows.push_back('{mk(OP_REL, 8'h07, 1, -1, 0, 0, 65536, 8'h40, 0), 1'b0, 0, 0});
        dir_rows.push_back('{mk(OP_REL, 8'h08, -1, 1, 0, 0, 65537, 8'h80, 0), 1'b0, 0, 0});
        dir_rows.push_back('{mk(OP_REL, 8'h09, 32767, -32768, 0, 0, 20'hFFFFF, 8'h00, 0),
                             1'b1, 16'd65535, 16'd0});
        dir_rows.push_back('{mk(OP_REL, 8'h0A, -32768, 32767, 0, 0, 0, 8'h11, 0),
                             1'b1, 16'd0, 16'd65535});
        dir_rows.push_back('{mk(OP_REL, 8'h0B, 0, 0, 0, 0, 20'h80000, 8'h22, -32768),
                             1'b0, 0, 0});
        dir_rows.push_back('{mk(OP_REL, 8'h0C, 100, -100, 0, 0, 65535, 8'h33, 0),
                             1'b0, 0, 0});
        dir_rows.push_back('{mk(OP_REL, 8'h0D, 10, -10, 0, 0, 131072, 8'h44, 1), 1'b0, 0, 0});
        dir_rows.push_back('{mk(OP_ABS, 8'hFF, 32767, 32767, 65535, 65535, 0, 8'h00, -1),
                             1'b1, 16'd32767, 16'd32767});
        dir_rows.push_back('{mk(OP_ABS, 8'h00, 0, 0, 0, 0, 0, 8'hFF, 1),
                             1'b1, 16'd0, 16'd0});
        dir_rows.push_back('{mk(OP_REL, 8'h0E, -1, -1, 65535, 65535, 0, 8'h55, 0),
                             1'b1, 16'd0, 16'd0});
        dir_rows.push_back('{mk(OP_REL, 8'h0F, 1023, 1023, 0, 0, 65537, 8'h66, 0), 1'b0, 0, 0});
        dir_rows.push_back('{mk(OP_ABS, 8'h10, 12345, -300, 40000, 500, 0, 8'h77, 0),
                             1'b0, 0, 0});
        dir_rows.push_back('{mk(OP_ABS, 8'h11, 32767, 32767, 1, 0, 0, 8'h88, 21845),
                             1'b1, 16'd65535, 16'd65535});
        dir_rows.push_back('{mk(OP_REL, 8'h55, -32768, -32768, 0, 0, 20'hFFFFF, 8'hAA, 0),
                             1'b1, 16'd0, 16'd0});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        track_x = 16'(VMAX / 2);
        track_y = 16'(VMAX / 2);

        foreach (dir_rows[k])
            send_report(dir_rows[k].req, dir_rows[k].pinned, dir_rows[k].px, dir_rows[k].py);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 21;
                    snk_idle_pct = 50;
                end
                1: begin
                    src_idle_pct = 50;
                    snk_idle_pct = 21;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                    // Stall the result side for a long stretch so the input backs up.
                    hold_request = 1'b1;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_report(rand_report(), 1'b0, 16'd0, 16'd0);
        end
        req_bus.valid <= 1'b0;

        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_events.size() != 0) begin
            $error("%0d expected results never arrived", pending_events.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("tb_pointer_coordinate_transform_core: done, clean");
        end else begin
            $display("tb_pointer_coordinate_transform_core: done, errors");
        end
        $finish;
    end

endmodule
